>>> rtl/hscu_pkg.sv
// Shared constants, register codes and pipeline control types for the heat stencil cell unit.
package hscu_pkg;

    localparam int TEMP_W    = 32;
    localparam int GAIN_W    = 32;
    localparam int FACES     = 6;
    localparam int MASK_W    = 6;
    localparam int LOSSY_W   = $clog2(FACES + 1);
    localparam int CFG_IDX_W = 3;
    localparam int FACE_YM   = 2;

    localparam int DEF_TEMP_FRACTION_BITS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONDUCTION_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONVECTION_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIATION_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_FLUX        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLUID_TEMP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN       = 3'd5;

    localparam logic [GAIN_W-1:0] RST_CONDUCTION_GAIN = 32'd15904801;
    localparam logic [GAIN_W-1:0] RST_CONVECTION_GAIN = 32'd687195;
    localparam logic [GAIN_W-1:0] RST_RADIATION_GAIN  = 32'd16735800;
    localparam logic [GAIN_W-1:0] RST_CPU_FLUX        = 32'd0;
    localparam logic [TEMP_W-1:0] RST_FLUID_TEMP      = 32'd19211878;
    localparam logic [GAIN_W-1:0] RST_STEP_GAIN       = 32'd110427904;

    localparam int PIPE_STAGES = 13;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] valid;
        logic [PIPE_STAGES-1:0] load;
    } hscu_pipe_t;

endpackage

>>> rtl/hscu_ifs.sv
// Channel interfaces: cell request, result, and configuration write.
interface hscu_cell_if import hscu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] center_temp;
    logic [TEMP_W-1:0] west_temp;
    logic [TEMP_W-1:0] east_temp;
    logic [TEMP_W-1:0] south_temp;
    logic [TEMP_W-1:0] north_temp;
    logic [TEMP_W-1:0] below_temp;
    logic [TEMP_W-1:0] above_temp;
    logic [MASK_W-1:0] face_mask;
    logic              cpu_contact;
    logic              hold_cell;

    modport source (
        output valid, center_temp, west_temp, east_temp, south_temp, north_temp,
               below_temp, above_temp, face_mask, cpu_contact, hold_cell,
        input  ready
    );
    modport sink (
        input  valid, center_temp, west_temp, east_temp, south_temp, north_temp,
               below_temp, above_temp, face_mask, cpu_contact, hold_cell,
        output ready
    );
endinterface

interface hscu_result_if import hscu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] new_temp;

    modport source (output valid, new_temp, input ready);
    modport sink (input valid, new_temp, output ready);
endinterface

interface hscu_cfg_if import hscu_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/hscu_pipe_ctrl.sv
// Valid bits and per-stage load enables for the stall-tolerant update pipeline.
module hscu_pipe_ctrl import hscu_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_ready,
    output hscu_pipe_t pipe
);

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] load;

    // A stage may load when it or any stage after it is empty, or the output drains.
    always_comb
    begin
        for (int i = 0; i < PIPE_STAGES; i++)
        begin
            load[i] = out_ready ||
                      ((valid_reg | PIPE_STAGES'((1 << i) - 1)) != {PIPE_STAGES{1'b1}});
        end
        valid_next = (load & {valid_reg[PIPE_STAGES-2:0], in_valid}) | (~load & valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = load[0];
    assign pipe.valid = valid_reg;
    assign pipe.load  = load;

endmodule

>>> rtl/heat_stencil_cell_update_unit.sv
// Top level: one explicit 7-point heat diffusion step per cell, fully pipelined.
//
// Usage:
//   src carries one cell per request: the center temperature, its six neighbours,
//   the exposed-face mask, the CPU contact flag and the hold flag. dst returns the
//   updated temperature (kelvin, TEMP_FRACTION_BITS fraction bits, saturated).
//   cfg writes the six gain/temperature registers by index; it is always ready and
//   should only be written while no request is in flight.
// Pipeline: 13 register stages (radiation needs T^2, then two chained multiplies
//   cut into 32x32 parts).
// Throughput: one request per cycle while dst is ready.
// Stall: when dst is not ready the stages fill up from the output backwards;
//   src.ready stays high while any stage is empty, so bubbles are squeezed out.
// Reset: rst_n clears all valid bits and loads the configuration registers with their defaults.
module heat_stencil_cell_update_unit import hscu_pkg::*; #(
    parameter int TEMP_FRACTION_BITS = DEF_TEMP_FRACTION_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    hscu_cfg_if.sink       cfg,
    hscu_cell_if.sink      src,
    hscu_result_if.source  dst
);

    localparam int F        = TEMP_FRACTION_BITS;
    localparam int LAST     = PIPE_STAGES - 1;
    localparam int COND_SH  = F + 8;
    localparam int COND_W   = 64 - COND_SH;
    localparam int CSUM_W   = COND_W + 4;
    localparam int CONV_SH  = F + 16;
    localparam int CONV_W   = 64 - CONV_SH;
    localparam int CONV_SW  = CONV_W + 1;
    localparam int RAD_SH   = 4 * F + 16;
    localparam int RAD_W    = 59;
    localparam int LOSS_W   = RAD_W + 1;
    localparam int LOSSX_W  = LOSS_W + 3;
    localparam int FLUX_W   = LOSSX_W + 1;
    localparam int MAG_W    = FLUX_W - 1;
    localparam int MAG_HI_W = MAG_W - 32;
    localparam int DPH_W    = MAG_HI_W + 32;
    localparam int DPROD_W  = MAG_W + 32;
    localparam int D_SH     = 48 - F;
    localparam int DELTA_W  = 34;

    localparam logic [127:0]         RAD_LIMIT   = 128'(1) << 58;
    localparam logic [DPROD_W-1:0]   DELTA_LIMIT = DPROD_W'(1) << 33;

    hscu_pipe_t pipe;

    hscu_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (src.valid),
        .in_ready  (src.ready),
        .out_ready (dst.ready),
        .pipe      (pipe)
    );

    // ---------------- configuration registers ----------------
    logic [GAIN_W-1:0] cond_gain_reg;
    logic [GAIN_W-1:0] conv_gain_reg;
    logic [GAIN_W-1:0] rad_gain_reg;
    logic [GAIN_W-1:0] cpu_flux_reg;
    logic [TEMP_W-1:0] fluid_temp_reg;
    logic [GAIN_W-1:0] step_gain_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cond_gain_reg  <= RST_CONDUCTION_GAIN;
            conv_gain_reg  <= RST_CONVECTION_GAIN;
            rad_gain_reg   <= RST_RADIATION_GAIN;
            cpu_flux_reg   <= RST_CPU_FLUX;
            fluid_temp_reg <= RST_FLUID_TEMP;
            step_gain_reg  <= RST_STEP_GAIN;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_CONDUCTION_GAIN: cond_gain_reg  <= cfg.data;
                REG_CONVECTION_GAIN: conv_gain_reg  <= cfg.data;
                REG_RADIATION_GAIN:  rad_gain_reg   <= cfg.data;
                REG_CPU_FLUX:        cpu_flux_reg   <= cfg.data;
                REG_FLUID_TEMP:      fluid_temp_reg <= cfg.data;
                REG_STEP_GAIN:       step_gain_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline registers ----------------
    logic [TEMP_W-1:0]         c_line_reg    [LAST];
    logic                      hold_line_reg [LAST];
    logic [LOSSY_W-1:0]        lossy_line_reg [0:7];
    logic signed [CONV_SW-1:0] conv_line_reg [2:6];
    logic signed [CSUM_W-1:0]  csum_line_reg [3:8];
    logic                      neg_line_reg  [9:11];

    // stage 0
    logic [TEMP_W-1:0]  s0_dmag_reg [FACES];
    logic [FACES-1:0]   s0_dneg_reg;
    logic [FACES-1:0]   s0_cond_en_reg;
    logic               s0_cpu_on_reg;
    logic [TEMP_W-1:0]  s0_fmag_reg;
    logic               s0_fneg_reg;
    logic [63:0]        s0_csq_reg;
    // stage 1
    logic [63:0]        s1_cprod_reg [FACES];
    logic [FACES-1:0]   s1_dneg_reg;
    logic [FACES-1:0]   s1_cond_en_reg;
    logic               s1_cpu_on_reg;
    logic [63:0]        s1_vprod_reg;
    logic               s1_fneg_reg;
    logic [63:0]        s1_rpl_reg;
    logic [63:0]        s1_rph_reg;
    logic [63:0]        s1_csq_reg;
    // stage 2
    logic signed [CSUM_W-1:0] s2_pair_reg [3];
    logic               s2_cpu_on_reg;
    logic [63:0]        s2_r1_reg;
    logic [63:0]        s2_csq_reg;
    // stage 3
    logic [63:0]        s3_pp_reg [4];
    // stage 4
    logic [64:0]        s4_mid_reg;
    logic [63:0]        s4_ll_reg;
    logic [63:0]        s4_hh_reg;
    // stage 5 .. 12
    logic [127:0]              s5_rprod_reg;
    logic [RAD_W-1:0]          s6_rad_reg;
    logic signed [LOSS_W-1:0]  s7_loss_reg;
    logic signed [LOSSX_W-1:0] s8_lossx_reg;
    logic [MAG_W-1:0]          s9_mag_reg;
    logic [63:0]               s10_dpl_reg;
    logic [DPH_W-1:0]          s10_dph_reg;
    logic [DELTA_W-1:0]        s11_delta_reg;
    logic [TEMP_W-1:0]         new_temp_reg;

    // ---------------- combinational next values ----------------
    logic [TEMP_W-1:0]  nb [FACES];
    logic [TEMP_W-1:0]  s0_dmag_next [FACES];
    logic [FACES-1:0]   s0_dneg_next;
    logic               s0_cpu_on_next;
    logic [LOSSY_W-1:0] s0_lossy_next;
    logic               s0_fneg_next;
    logic [TEMP_W-1:0]  s0_fmag_next;
    logic [63:0]        s0_csq_next;

    logic [CSUM_W-1:0]         cond_mag  [FACES];
    logic signed [CSUM_W-1:0]  cond_term [FACES];
    logic [CONV_SW-1:0]        conv_mag;
    logic signed [CONV_SW-1:0] s2_conv_next;

    logic signed [CSUM_W-1:0]  s3_csum_next;
    logic [127:0]              rad_shifted;
    logic [RAD_W-1:0]          s6_rad_next;
    logic signed [FLUX_W-1:0]  flux;
    logic signed [FLUX_W-1:0]  flux_neg;
    logic [DPROD_W-1:0]        dprod;
    logic [DPROD_W-1:0]        dshifted;
    logic [DELTA_W-1:0]        s11_delta_next;
    logic [TEMP_W+2:0]         up_sum;
    logic [TEMP_W-1:0]         new_temp_next;

    always_comb
    begin
        nb[0] = src.west_temp;
        nb[1] = src.east_temp;
        nb[2] = src.south_temp;
        nb[3] = src.north_temp;
        nb[4] = src.below_temp;
        nb[5] = src.above_temp;
        for (int f = 0; f < FACES; f++)
        begin
            s0_dneg_next[f] = nb[f] < src.center_temp;
            s0_dmag_next[f] = s0_dneg_next[f] ? src.center_temp - nb[f]
                                              : nb[f] - src.center_temp;
        end
        s0_cpu_on_next = src.face_mask[FACE_YM] & src.cpu_contact;
        // exposed faces lose heat, except the south (FACE_YM) face in CPU contact
        s0_lossy_next = '0;
        for (int f = 0; f < FACES; f++)
        begin
            s0_lossy_next = s0_lossy_next + LOSSY_W'(src.face_mask[f]);
        end
        s0_lossy_next = s0_lossy_next - LOSSY_W'(s0_cpu_on_next);
        s0_fneg_next = src.center_temp < fluid_temp_reg;
        s0_fmag_next = s0_fneg_next ? fluid_temp_reg - src.center_temp
                                    : src.center_temp - fluid_temp_reg;
        s0_csq_next  = 64'(src.center_temp) * 64'(src.center_temp);
    end

    always_comb
    begin
        for (int f = 0; f < FACES; f++)
        begin
            cond_mag[f]  = CSUM_W'(s1_cprod_reg[f] >> COND_SH);
            cond_term[f] = s1_dneg_reg[f] ? -$signed(cond_mag[f]) : $signed(cond_mag[f]);
            if (!s1_cond_en_reg[f])
            begin
                cond_term[f] = '0;
            end
        end
        conv_mag     = CONV_SW'(s1_vprod_reg >> CONV_SH);
        s2_conv_next = s1_fneg_reg ? -$signed(conv_mag) : $signed(conv_mag);
    end

    always_comb
    begin
        s3_csum_next = s2_pair_reg[0] + s2_pair_reg[1] + s2_pair_reg[2];
        if (s2_cpu_on_reg)
        begin
            s3_csum_next = s3_csum_next + $signed(CSUM_W'(cpu_flux_reg));
        end

        rad_shifted = s5_rprod_reg >> RAD_SH;
        s6_rad_next = (rad_shifted > RAD_LIMIT) ? RAD_W'(RAD_LIMIT) : RAD_W'(rad_shifted);

        flux     = FLUX_W'(csum_line_reg[8]) - FLUX_W'(s8_lossx_reg);
        flux_neg = -flux;

        dprod    = {s10_dph_reg, 32'b0} + DPROD_W'(s10_dpl_reg);
        dshifted = dprod >> D_SH;
        s11_delta_next = (dshifted > DELTA_LIMIT) ? DELTA_W'(DELTA_LIMIT)
                                                  : DELTA_W'(dshifted);

        up_sum = {3'b0, c_line_reg[LAST-1]} + {1'b0, s11_delta_reg};
        if (hold_line_reg[LAST-1])
        begin
            new_temp_next = c_line_reg[LAST-1];
        end
        else if (neg_line_reg[11])
        begin
            if (s11_delta_reg > DELTA_W'(c_line_reg[LAST-1]))
            begin
                new_temp_next = '0;
            end
            else
            begin
                new_temp_next = c_line_reg[LAST-1] - s11_delta_reg[TEMP_W-1:0];
            end
        end
        else if (up_sum[TEMP_W+2:TEMP_W] != 3'b0)
        begin
            new_temp_next = {TEMP_W{1'b1}};
        end
        else
        begin
            new_temp_next = up_sum[TEMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        // carried fields
        if (pipe.load[0])
        begin
            c_line_reg[0]     <= src.center_temp;
            hold_line_reg[0]  <= src.hold_cell;
            lossy_line_reg[0] <= s0_lossy_next;
        end
        for (int k = 1; k < LAST; k++)
        begin
            if (pipe.load[k])
            begin
                c_line_reg[k]    <= c_line_reg[k-1];
                hold_line_reg[k] <= hold_line_reg[k-1];
            end
        end
        for (int k = 1; k <= 7; k++)
        begin
            if (pipe.load[k])
            begin
                lossy_line_reg[k] <= lossy_line_reg[k-1];
            end
        end
        for (int k = 3; k <= 6; k++)
        begin
            if (pipe.load[k])
            begin
                conv_line_reg[k] <= conv_line_reg[k-1];
            end
        end
        for (int k = 4; k <= 8; k++)
        begin
            if (pipe.load[k])
            begin
                csum_line_reg[k] <= csum_line_reg[k-1];
            end
        end
        for (int k = 10; k <= 11; k++)
        begin
            if (pipe.load[k])
            begin
                neg_line_reg[k] <= neg_line_reg[k-1];
            end
        end

        // stage 0: differences and T^2
        if (pipe.load[0])
        begin
            s0_dmag_reg    <= s0_dmag_next;
            s0_dneg_reg    <= s0_dneg_next;
            s0_cond_en_reg <= ~src.face_mask;
            s0_cpu_on_reg  <= s0_cpu_on_next;
            s0_fmag_reg    <= s0_fmag_next;
            s0_fneg_reg    <= s0_fneg_next;
            s0_csq_reg     <= s0_csq_next;
        end
        // stage 1: gain products
        if (pipe.load[1])
        begin
            for (int f = 0; f < FACES; f++)
            begin
                s1_cprod_reg[f] <= 64'(s0_dmag_reg[f]) * 64'(cond_gain_reg);
            end
            s1_dneg_reg    <= s0_dneg_reg;
            s1_cond_en_reg <= s0_cond_en_reg;
            s1_cpu_on_reg  <= s0_cpu_on_reg;
            s1_vprod_reg   <= 64'(s0_fmag_reg) * 64'(conv_gain_reg);
            s1_fneg_reg    <= s0_fneg_reg;
            s1_rpl_reg     <= 64'(s0_csq_reg[31:0]) * 64'(rad_gain_reg);
            s1_rph_reg     <= 64'(s0_csq_reg[63:32]) * 64'(rad_gain_reg);
            s1_csq_reg     <= s0_csq_reg;
        end
        // stage 2: signed conduction pairs, convection, (T^2 * gain) >> 32
        if (pipe.load[2])
        begin
            for (int p = 0; p < 3; p++)
            begin
                s2_pair_reg[p] <= cond_term[2*p] + cond_term[2*p+1];
            end
            s2_cpu_on_reg    <= s1_cpu_on_reg;
            conv_line_reg[2] <= s2_conv_next;
            s2_r1_reg        <= s1_rph_reg + (s1_rpl_reg >> 32);
            s2_csq_reg       <= s1_csq_reg;
        end
        // stage 3: conduction total, radiation partial products
        if (pipe.load[3])
        begin
            csum_line_reg[3] <= s3_csum_next;
            s3_pp_reg[0]     <= 64'(s2_r1_reg[31:0])  * 64'(s2_csq_reg[31:0]);
            s3_pp_reg[1]     <= 64'(s2_r1_reg[31:0])  * 64'(s2_csq_reg[63:32]);
            s3_pp_reg[2]     <= 64'(s2_r1_reg[63:32]) * 64'(s2_csq_reg[31:0]);
            s3_pp_reg[3]     <= 64'(s2_r1_reg[63:32]) * 64'(s2_csq_reg[63:32]);
        end
        if (pipe.load[4])
        begin
            s4_mid_reg <= 65'(s3_pp_reg[1]) + 65'(s3_pp_reg[2]);
            s4_ll_reg  <= s3_pp_reg[0];
            s4_hh_reg  <= s3_pp_reg[3];
        end
        if (pipe.load[5])
        begin
            s5_rprod_reg <= {s4_hh_reg, 64'b0} + {31'b0, s4_mid_reg, 32'b0}
                          + {64'b0, s4_ll_reg};
        end
        if (pipe.load[6])
        begin
            s6_rad_reg <= s6_rad_next;
        end
        if (pipe.load[7])
        begin
            s7_loss_reg <= $signed({1'b0, s6_rad_reg}) + LOSS_W'(conv_line_reg[6]);
        end
        if (pipe.load[8])
        begin
            s8_lossx_reg <= LOSSX_W'(s7_loss_reg)
                          * LOSSX_W'($signed({1'b0, lossy_line_reg[7]}));
        end
        if (pipe.load[9])
        begin
            neg_line_reg[9] <= flux[FLUX_W-1];
            s9_mag_reg      <= flux[FLUX_W-1] ? MAG_W'(flux_neg) : MAG_W'(flux);
        end
        if (pipe.load[10])
        begin
            s10_dpl_reg <= 64'(s9_mag_reg[31:0]) * 64'(step_gain_reg);
            s10_dph_reg <= DPH_W'(s9_mag_reg[MAG_W-1:32]) * DPH_W'(step_gain_reg);
        end
        if (pipe.load[11])
        begin
            s11_delta_reg <= s11_delta_next;
        end
        if (pipe.load[LAST])
        begin
            new_temp_reg <= new_temp_next;
        end
    end

    assign dst.valid    = pipe.valid[LAST];
    assign dst.new_temp = new_temp_reg;

    // ---------------- assertions ----------------
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        src.valid && src.ready |=> pipe.valid[0])
        else $error("accepted request did not enter the first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        pipe.valid[LAST-1] && !pipe.load[LAST-1]
        |=> pipe.valid[LAST-1] && $stable(c_line_reg[LAST-1]))
        else $error("stalled stage lost or changed its request");

    a_rad_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pipe.valid[6] |-> s6_rad_reg <= RAD_W'(RAD_LIMIT))
        else $error("radiation term above its limit");

    a_heat_gain_up: assert property (@(posedge clk) disable iff (!rst_n)
        pipe.load[LAST] && pipe.valid[LAST-1] && !hold_line_reg[LAST-1] && !neg_line_reg[11]
        |=> new_temp_reg >= $past(c_line_reg[LAST-1]))
        else $error("non-negative flux lowered the temperature");

endmodule

>>> verif/heat_stencil_cell_update_unit_checker.sv
`timescale 1ns / 1ps
// Watches the channels, predicts each cell update and compares it with the returned temperature.
module heat_stencil_cell_update_unit_checker import hscu_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    hscu_cfg_if    cfg,
    hscu_cell_if   src,
    hscu_result_if dst,
    output int     mismatch_count,
    output int     results_pending
);

    localparam int          TFB        = DEF_TEMP_FRACTION_BITS;
    localparam logic [63:0] RAD_CAP    = 64'd1 << 58;
    localparam logic [63:0] DELTA_CAP  = 64'd1 << 33;
    localparam longint      TEMP_CEIL  = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [TEMP_W-1:0]             center;
        logic [FACES-1:0][TEMP_W-1:0]  nb;
        logic [MASK_W-1:0]             mask;
        logic                          contact;
        logic                          hold;
    } stencil_cell_t;

    logic [GAIN_W-1:0] conduction_gain;
    logic [GAIN_W-1:0] convection_gain;
    logic [GAIN_W-1:0] radiation_gain;
    logic [GAIN_W-1:0] cpu_flux;
    logic [TEMP_W-1:0] fluid_temp;
    logic [GAIN_W-1:0] step_gain;

    logic [TEMP_W-1:0] expected_temps [$];

    // full 128-bit product, shifted down, clipped to 64 bits
    function automatic logic [63:0] clipped_product(input logic [63:0] a, input logic [63:0] b,
                                                    input int unsigned sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        if (p[127:64] != '0)
            return '1;
        return p[63:0];
    endfunction

    function automatic longint face_conduction(input logic [TEMP_W-1:0] nb,
                                               input logic [TEMP_W-1:0] c);
        logic [63:0] mag;
        if (nb >= c)
        begin
            mag = clipped_product(64'(nb - c), 64'(conduction_gain), TFB + 8);
            return longint'(mag);
        end
        mag = clipped_product(64'(c - nb), 64'(conduction_gain), TFB + 8);
        return -longint'(mag);
    endfunction

    // positive means heat leaves through the face
    function automatic longint face_loss(input logic [TEMP_W-1:0] c);
        logic [63:0] sq;
        logic [63:0] rad;
        longint      loss;
        sq  = 64'(c) * 64'(c);
        rad = clipped_product(clipped_product(sq, 64'(radiation_gain), 32), sq, 4 * TFB + 16);
        if (rad > RAD_CAP)
            rad = RAD_CAP;
        loss = longint'(rad);
        if (c >= fluid_temp)
            loss += longint'(clipped_product(64'(c - fluid_temp), 64'(convection_gain), TFB + 16));
        else
            loss -= longint'(clipped_product(64'(fluid_temp - c), 64'(convection_gain), TFB + 16));
        return loss;
    endfunction

    function automatic logic [TEMP_W-1:0] next_cell_temp(input stencil_cell_t r);
        longint      flux;
        longint      next;
        logic [63:0] mag;
        logic [63:0] delta;
        int          lossy;
        flux  = 0;
        lossy = 0;
        if (r.hold)
            return r.center;
        for (int f = 0; f < FACES; f++)
        begin
            if (!r.mask[f])
                flux += face_conduction(r.nb[f], r.center);
            else if (f == FACE_YM && r.contact)
                flux += longint'({32'd0, cpu_flux});
            else
                lossy++;
        end
        if (lossy != 0)
            flux -= face_loss(r.center) * lossy;
        mag   = (flux < 0) ? 64'(-flux) : 64'(flux);
        delta = clipped_product(mag, 64'(step_gain), 48 - TFB);
        if (delta > DELTA_CAP)
            delta = DELTA_CAP;
        if (flux < 0)
            next = longint'({32'd0, r.center}) - longint'(delta);
        else
            next = longint'({32'd0, r.center}) + longint'(delta);
        if (next < 0)
            next = 0;
        if (next > TEMP_CEIL)
            next = TEMP_CEIL;
        return next[TEMP_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        stencil_cell_t     req;
        logic [TEMP_W-1:0] want;
        if (!rst_n)
        begin
            conduction_gain = RST_CONDUCTION_GAIN;
            convection_gain = RST_CONVECTION_GAIN;
            radiation_gain  = RST_RADIATION_GAIN;
            cpu_flux        = RST_CPU_FLUX;
            fluid_temp      = RST_FLUID_TEMP;
            step_gain       = RST_STEP_GAIN;
            expected_temps.delete();
            results_pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_CONDUCTION_GAIN: conduction_gain = cfg.data;
                    REG_CONVECTION_GAIN: convection_gain = cfg.data;
                    REG_RADIATION_GAIN:  radiation_gain  = cfg.data;
                    REG_CPU_FLUX:        cpu_flux        = cfg.data;
                    REG_FLUID_TEMP:      fluid_temp      = cfg.data;
                    REG_STEP_GAIN:       step_gain       = cfg.data;
                    default: ;
                endcase
            end
            if (src.valid && src.ready)
            begin
                req.center  = src.center_temp;
                req.nb      = {src.above_temp, src.below_temp, src.north_temp,
                               src.south_temp, src.east_temp, src.west_temp};
                req.mask    = src.face_mask;
                req.contact = src.cpu_contact;
                req.hold    = src.hold_cell;
                expected_temps.push_back(next_cell_temp(req));
            end
            if (dst.valid && dst.ready)
            begin
                if (expected_temps.size() == 0)
                    report_mismatch($sformatf("new_temp %h with no request outstanding",
                                              dst.new_temp));
                else
                begin
                    want = expected_temps.pop_front();
                    if (dst.new_temp !== want)
                        report_mismatch($sformatf("new_temp got %h want %h",
                                                  dst.new_temp, want));
                end
            end
            results_pending = expected_temps.size();
        end
    end

endmodule

>>> verif/heat_stencil_cell_update_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, register settings, cell stimulus and the final verdict.
module heat_stencil_cell_update_unit_tb;
    import hscu_pkg::*;

    localparam int CELLS_PER_PHASE = 100;
    localparam int PHASES          = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 2 * PIPE_STAGES + 4;

    localparam logic [TEMP_W-1:0] ONE_KELVIN = 32'h0001_0000;
    localparam logic [GAIN_W-1:0] NOMINAL_CPU_FLUX = 40 * ONE_KELVIN;

    // indexes past the register file; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [TEMP_W-1:0]             center;
        logic [FACES-1:0][TEMP_W-1:0]  nb;
        logic [MASK_W-1:0]             mask;
        logic                          contact;
        logic                          hold;
    } stencil_req_t;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   mismatch_count;
    int   results_pending;
    int   cycles_elapsed;

    hscu_cfg_if    cfg_ch ();
    hscu_cell_if   cell_ch ();
    hscu_result_if result_ch ();

    heat_stencil_cell_update_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .src   (cell_ch),
        .dst   (result_ch)
    );

    heat_stencil_cell_update_unit_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_ch),
        .src             (cell_ch),
        .dst             (result_ch),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        cycles_elapsed <= cycles_elapsed + 1;
        if (cycles_elapsed == CYCLE_LIMIT)
        begin
            $display("timeout with %0d requests outstanding", results_pending);
            $display("heat_stencil_cell_update_unit_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [GAIN_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_cell(input stencil_req_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cell_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cell_ch.valid       <= 1'b1;
        cell_ch.center_temp <= r.center;
        cell_ch.west_temp   <= r.nb[0];
        cell_ch.east_temp   <= r.nb[1];
        cell_ch.south_temp  <= r.nb[2];
        cell_ch.north_temp  <= r.nb[3];
        cell_ch.below_temp  <= r.nb[4];
        cell_ch.above_temp  <= r.nb[5];
        cell_ch.face_mask   <= r.mask;
        cell_ch.cpu_contact <= r.contact;
        cell_ch.hold_cell   <= r.hold;
        @(posedge clk);
        while (!cell_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // caller lowers valid first
    task automatic wait_drained();
        while (results_pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apply_settings(input int phase);
        logic [GAIN_W-1:0] v [6];
        v = '{RST_CONDUCTION_GAIN, RST_CONVECTION_GAIN, RST_RADIATION_GAIN,
              NOMINAL_CPU_FLUX, RST_FLUID_TEMP, RST_STEP_GAIN};
        case (phase)
            1: v = '{default: '1};
            2: v = '{default: '0};
            3, 5:
            begin
                foreach (v[i])
                    v[i] = $urandom;
            end
            4:
            begin
                // hot coolant with strong convection
                v[1] = '1;
                v[4] = '1;
            end
            6:
            begin
                v[0] = $urandom_range(32'h0400_0000);
                v[2] = $urandom_range(32'h1000_0000);
                v[3] = $urandom_range(200 * ONE_KELVIN);
                v[5] = $urandom_range(32'h4000_0000);
            end
            7:
            begin
                v[2] = '1;
                v[4] = '0;
            end
            default: ;
        endcase
        write_reg(REG_CONDUCTION_GAIN, v[0]);
        write_reg(REG_CONVECTION_GAIN, v[1]);
        write_reg(REG_RADIATION_GAIN,  v[2]);
        write_reg(REG_CPU_FLUX,        v[3]);
        write_reg(REG_FLUID_TEMP,      v[4]);
        write_reg(REG_STEP_GAIN,       v[5]);
        write_reg(REG_SPARE_6, $urandom);
        write_reg(REG_SPARE_7, $urandom);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic stencil_req_t directed_cell(input logic [TEMP_W-1:0] c,
                                                   input logic [TEMP_W-1:0] n,
                                                   input logic [MASK_W-1:0] mask,
                                                   input logic contact, input logic hold);
        stencil_req_t r;
        r.center = c;
        for (int f = 0; f < FACES; f++)
            r.nb[f] = n;
        r.mask    = mask;
        r.contact = contact;
        r.hold    = hold;
        return r;
    endfunction

    function automatic stencil_req_t random_cell();
        stencil_req_t      r;
        int                kind;
        logic [TEMP_W-1:0] t;
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            // plausible heat sink temperatures, neighbors within 16 kelvin
            r.center = $urandom_range(420 * ONE_KELVIN, 280 * ONE_KELVIN);
            for (int f = 0; f < FACES; f++)
                r.nb[f] = r.center - 16 * ONE_KELVIN + $urandom_range(32 * ONE_KELVIN);
        end
        else if (kind < 85)
        begin
            r.center = $urandom;
            for (int f = 0; f < FACES; f++)
                r.nb[f] = $urandom;
        end
        else
        begin
            for (int f = 0; f <= FACES; f++)
            begin
                case ($urandom_range(4))
                    0: t = '0;
                    1: t = '1;
                    2: t = 32'h8000_0000;
                    3: t = RST_FLUID_TEMP + $urandom_range(2 * ONE_KELVIN) - ONE_KELVIN;
                    default: t = $urandom;
                endcase
                if (f == FACES)
                    r.center = t;
                else
                    r.nb[f] = t;
            end
        end
        r.mask    = ($urandom_range(3) == 0) ? '0 : MASK_W'($urandom_range(63));
        r.contact = 1'($urandom_range(1));
        r.hold    = ($urandom_range(9) == 0);
        return r;
    endfunction

    initial
    begin
        stencil_req_t r;
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        cell_ch.valid       = 1'b0;
        cell_ch.center_temp = '0;
        cell_ch.west_temp   = '0;
        cell_ch.east_temp   = '0;
        cell_ch.south_temp  = '0;
        cell_ch.north_temp  = '0;
        cell_ch.below_temp  = '0;
        cell_ch.above_temp  = '0;
        cell_ch.face_mask   = '0;
        cell_ch.cpu_contact = 1'b0;
        cell_ch.hold_cell   = 1'b0;
        result_ch.ready     = 1'b0;
        src_idle_pct        = 0;
        sink_stall_pct      = 0;
        cycles_elapsed      = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed cases run on reset values, except a CPU flux so contact shows up
        write_reg(REG_CPU_FLUX, NOMINAL_CPU_FLUX);
        cfg_ch.valid <= 1'b0;

        send_cell(directed_cell('0, '0, 6'h00, 1'b0, 1'b0));
        send_cell(directed_cell('1, '1, 6'h00, 1'b0, 1'b0));
        send_cell(directed_cell('0, '1, 6'h00, 1'b0, 1'b0));
        send_cell(directed_cell('1, '0, 6'h00, 1'b0, 1'b0));
        r = directed_cell(300 * ONE_KELVIN, '0, 6'h00, 1'b0, 1'b0);
        for (int f = 0; f < FACES; f++)
            r.nb[f] = (f % 2 == 1) ? '1 : 290 * ONE_KELVIN + f;
        send_cell(r);
        send_cell(directed_cell(300 * ONE_KELVIN, 310 * ONE_KELVIN, 6'h00, 1'b0, 1'b1));
        send_cell(directed_cell('1, '0, 6'h3F, 1'b1, 1'b1));
        // exposed faces: neighbor values must not matter
        send_cell(directed_cell(350 * ONE_KELVIN, 300 * ONE_KELVIN, 6'h3F, 1'b0, 1'b0));
        send_cell(directed_cell(350 * ONE_KELVIN, '0, 6'h3F, 1'b0, 1'b0));
        send_cell(directed_cell(350 * ONE_KELVIN, 300 * ONE_KELVIN, 6'h04, 1'b1, 1'b0));
        send_cell(directed_cell(350 * ONE_KELVIN, 300 * ONE_KELVIN, 6'h00, 1'b1, 1'b0));
        send_cell(directed_cell(350 * ONE_KELVIN, 300 * ONE_KELVIN, 6'h3F, 1'b1, 1'b0));
        for (int f = 0; f < FACES; f++)
            send_cell(directed_cell(330 * ONE_KELVIN, 320 * ONE_KELVIN, MASK_W'(1 << f),
                                    1'b0, 1'b0));
        send_cell(directed_cell(RST_FLUID_TEMP - 10 * ONE_KELVIN, 290 * ONE_KELVIN, 6'h3F,
                                1'b0, 1'b0));
        send_cell(directed_cell(RST_FLUID_TEMP, RST_FLUID_TEMP, 6'h3F, 1'b0, 1'b0));
        send_cell(directed_cell('1, '1, 6'h3F, 1'b0, 1'b0));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            cell_ch.valid <= 1'b0;
            wait_drained();
            apply_settings(phase);
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
                default: begin src_idle_pct = 32; sink_stall_pct = 32; end
            endcase
            for (int i = 0; i < CELLS_PER_PHASE; i++)
            begin
                if (i == CELLS_PER_PHASE / 2)
                begin
                    // hold off until the pipeline has emptied
                    cell_ch.valid <= 1'b0;
                    wait_drained();
                end
                send_cell(random_cell());
            end
        end

        cell_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("heat_stencil_cell_update_unit_tb: clean");
        else
            $display("heat_stencil_cell_update_unit_tb: errors");
        $finish;
    end

endmodule
